/* rtl/refcounted_range_table_macros.svh */
// Assertion helpers for the file that checks this block.
`ifndef REFCOUNTED_RANGE_TABLE_MACROS_SVH
`define REFCOUNTED_RANGE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRT_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRT_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* rtl/rrt_pkg.sv */
`default_nettype none
package rrt_pkg;

	// Address width of the address and length fields on the ports.
	localparam int ADDR_BITS = 48;

	typedef logic [ADDR_BITS-1:0] addr_t;
	// Address with one carry bit, so that an end of 2^ADDR_BITS fits.
	typedef logic [ADDR_BITS:0]   addr_x_t;

	localparam logic FUNC_ADD    = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef struct packed {
		logic  func;
		addr_t first_addr;
		addr_t range_length;
	} req_t;

	typedef struct packed {
		logic  part_valid;
		addr_t part_start;
		addr_t part_length;
		logic  table_full;
		logic  last;
	} rsp_t;

	// One accepted request, with its end already clipped.
	typedef struct packed {
		logic    func;
		addr_t   start;
		addr_x_t end_addr;
		logic    noop;
	} work_t;

	// A piece kept as start and exclusive end.
	typedef struct packed {
		addr_t   start;
		addr_x_t end_addr;
	} piece_t;

	typedef struct packed {
		logic   we;
		piece_t piece;
	} piece_wr_t;

	// Handoff from the table walk to the result stage.
	typedef struct packed {
		logic valid;
		logic dropped;
	} hand_t;

	typedef enum logic [2:0] {
		W_IDLE,
		W_RD,
		W_EVAL,
		W_WR2,
		W_TAIL,
		W_DONE
	} walk_state_t;

endpackage
`default_nettype wire

/* rtl/rrt_walk.sv */
`default_nettype none
module rrt_walk #(
	parameter int TABLE_DEPTH = 16,
	parameter int REF_BITS = 16,
	localparam int PW = $clog2(TABLE_DEPTH + 3),
	localparam int PIW = $clog2(TABLE_DEPTH + 2)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire rrt_pkg::work_t    work,
	input  wire logic              emit_busy,
	output logic                   idle,
	output rrt_pkg::piece_wr_t     pc_wr,
	output logic [PIW-1:0]         pc_addr,
	output rrt_pkg::hand_t         hand,
	output logic [PW-1:0]          hand_count
);

	localparam int A = rrt_pkg::ADDR_BITS;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int MD = 2 ** (IW + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [REF_BITS-1:0] REF_MAX = '1;
	localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

	typedef struct packed {
		rrt_pkg::addr_t   start;
		rrt_pkg::addr_x_t end_addr;
		logic [REF_BITS-1:0] refs;
	} ent_t;

	// Two table halves: the walk reads the current one and builds the next.
	ent_t mem [MD];
	ent_t rdata_q;

	rrt_pkg::walk_state_t st_q, st_d;
	logic bank_q, bank_d;
	logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d, wr_q, wr_d, ins_q, ins_d;
	logic [PW-1:0] npc_q, npc_d;
	logic drop_q, drop_d;
	ent_t hold_q, hold_d;
	logic hold_pc_q, hold_pc_d;
	rrt_pkg::addr_x_t cur_q, cur_d;
	logic func_q, noop_q;
	rrt_pkg::addr_x_t s_q, end_q;

	logic rd_en, tw_en;
	ent_t push_data;
	logic push_en, push_gate, push_ins;
	logic piece_en;
	rrt_pkg::addr_x_t piece_s, piece_e;
	rrt_pkg::addr_x_t es, ee;
	logic ovl, zero, add_room;
	logic [REF_BITS-1:0] rinc, rdec;

	// Next state, table writes and piece writes.
	always_comb begin
		st_d = st_q;
		bank_d = bank_q;
		cnt_d = cnt_q;
		idx_d = idx_q;
		wr_d = wr_q;
		ins_d = ins_q;
		npc_d = npc_q;
		drop_d = drop_q;
		hold_d = hold_q;
		hold_pc_d = hold_pc_q;
		cur_d = cur_q;
		rd_en = 1'b0;
		tw_en = 1'b0;
		push_en = 1'b0;
		push_gate = 1'b1;
		push_ins = 1'b0;
		push_data = rdata_q;
		piece_en = 1'b0;
		piece_s = cur_q;
		piece_e = cur_q;
		hand.valid = 1'b0;
		hand.dropped = drop_q;
		es = {1'b0, rdata_q.start};
		ee = rdata_q.end_addr;
		ovl = (ee > s_q) && (es < end_q);
		rinc = (rdata_q.refs == REF_MAX) ? rdata_q.refs : rdata_q.refs + REF_ONE;
		rdec = rdata_q.refs - REF_ONE;
		zero = (rdec == '0);
		add_room = ({1'b0, cnt_q} + {1'b0, ins_q}) < {1'b0, DEPTH_C};
		case (st_q)
			rrt_pkg::W_IDLE: begin
				if (start) begin
					st_d = work.noop ? rrt_pkg::W_DONE : rrt_pkg::W_RD;
					idx_d = '0;
					wr_d = '0;
					ins_d = '0;
					npc_d = '0;
					drop_d = 1'b0;
					cur_d = {1'b0, work.start};
				end
			end
			rrt_pkg::W_RD: begin
				if (idx_q < cnt_q) begin
					rd_en = 1'b1;
					st_d = rrt_pkg::W_EVAL;
				end else begin
					st_d = rrt_pkg::W_TAIL;
				end
			end
			rrt_pkg::W_EVAL: begin
				idx_d = idx_q + CW'(1);
				st_d = rrt_pkg::W_RD;
				if (!ovl) begin
					if (func_q == rrt_pkg::FUNC_ADD && es >= end_q && cur_q < end_q) begin
						// First entry above the range: the uncovered tail goes in before it.
						piece_en = 1'b1;
						piece_s = cur_q;
						piece_e = end_q;
						push_en = 1'b1;
						push_gate = add_room;
						push_ins = 1'b1;
						push_data = '{start: cur_q[A-1:0], end_addr: end_q, refs: REF_ONE};
						hold_d = rdata_q;
						hold_pc_d = 1'b0;
						cur_d = end_q;
						st_d = rrt_pkg::W_WR2;
					end else begin
						push_en = 1'b1;
					end
				end else if (func_q == rrt_pkg::FUNC_ADD) begin
					cur_d = (ee > cur_q) ? ee : cur_q;
					if (es > cur_q) begin
						// Uncovered gap before this entry: emit it, insert it if room.
						piece_en = 1'b1;
						piece_s = cur_q;
						piece_e = es;
						push_en = 1'b1;
						push_gate = add_room;
						push_ins = 1'b1;
						push_data = '{start: cur_q[A-1:0], end_addr: es, refs: REF_ONE};
						hold_d = '{start: rdata_q.start, end_addr: ee, refs: rinc};
						hold_pc_d = 1'b0;
						st_d = rrt_pkg::W_WR2;
					end else begin
						push_en = 1'b1;
						push_data = '{start: rdata_q.start, end_addr: ee, refs: rinc};
					end
				end else if (rdata_q.refs != '0) begin
					// Remove: keep the outside parts with the lowered count.
					if (es < s_q) begin
						push_en = 1'b1;
						push_data = '{start: rdata_q.start, end_addr: s_q, refs: rdec};
						piece_en = zero;
						piece_s = es;
						piece_e = s_q;
					end else if (zero && ee <= end_q) begin
						piece_en = 1'b1;
						piece_s = es;
						piece_e = ee;
					end
					if (ee > end_q) begin
						hold_d = '{start: end_q[A-1:0], end_addr: ee, refs: rdec};
						hold_pc_d = zero;
						st_d = rrt_pkg::W_WR2;
					end
				end
			end
			rrt_pkg::W_WR2: begin
				push_en = 1'b1;
				push_data = hold_q;
				piece_en = hold_pc_q;
				piece_s = {1'b0, hold_q.start};
				piece_e = hold_q.end_addr;
				st_d = rrt_pkg::W_RD;
			end
			rrt_pkg::W_TAIL: begin
				if (func_q == rrt_pkg::FUNC_ADD && cur_q < end_q) begin
					piece_en = 1'b1;
					piece_s = cur_q;
					piece_e = end_q;
					push_en = 1'b1;
					push_gate = add_room;
					push_ins = 1'b1;
					push_data = '{start: cur_q[A-1:0], end_addr: end_q, refs: REF_ONE};
				end
				st_d = rrt_pkg::W_DONE;
			end
			rrt_pkg::W_DONE: begin
				hand.valid = 1'b1;
				if (!noop_q) begin
					bank_d = ~bank_q;
					cnt_d = wr_q;
				end
				st_d = rrt_pkg::W_IDLE;
			end
			default: begin
				st_d = rrt_pkg::W_IDLE;
			end
		endcase
		// Append to the new table while it has room, otherwise flag the drop.
		if (push_en) begin
			if (push_gate && wr_q < DEPTH_C) begin
				tw_en = 1'b1;
				wr_d = wr_q + CW'(1);
				if (push_ins) begin
					ins_d = ins_q + CW'(1);
				end
			end else begin
				drop_d = 1'b1;
			end
		end
		if (piece_en) begin
			npc_d = npc_q + PW'(1);
		end
	end

	assign pc_wr.we = piece_en;
	assign pc_wr.piece.start = piece_s[A-1:0];
	assign pc_wr.piece.end_addr = piece_e;
	assign pc_addr = npc_q[PIW-1:0];
	assign hand_count = npc_q;
	assign idle = (st_q == rrt_pkg::W_IDLE) && !emit_busy;

	// Table memory: reads and writes go to different halves, so they never collide.
	always_ff @(posedge clk) begin
		if (tw_en) begin
			mem[{~bank_q, wr_q[IW-1:0]}] <= push_data;
		end
		if (rd_en) begin
			rdata_q <= mem[{bank_q, idx_q[IW-1:0]}];
		end
	end

	// Request operands.
	always_ff @(posedge clk) begin
		if (st_q == rrt_pkg::W_IDLE && start) begin
			func_q <= work.func;
			s_q <= {1'b0, work.start};
			end_q <= work.end_addr;
			noop_q <= work.noop;
		end
		hold_q <= hold_d;
		hold_pc_q <= hold_pc_d;
		cur_q <= cur_d;
	end

	// State register and walk counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rrt_pkg::W_IDLE;
			bank_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
			wr_q <= '0;
			ins_q <= '0;
			npc_q <= '0;
			drop_q <= 1'b0;
		end else begin
			st_q <= st_d;
			bank_q <= bank_d;
			cnt_q <= cnt_d;
			idx_q <= idx_d;
			wr_q <= wr_d;
			ins_q <= ins_d;
			npc_q <= npc_d;
			drop_q <= drop_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/rrt_emit.sv */
`default_nettype none
module rrt_emit #(
	parameter int TABLE_DEPTH = 16,
	localparam int PW = $clog2(TABLE_DEPTH + 3),
	localparam int PIW = $clog2(TABLE_DEPTH + 2)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rrt_pkg::piece_wr_t pc_wr,
	input  wire logic [PIW-1:0]     pc_addr,
	input  wire rrt_pkg::hand_t     hand,
	input  wire logic [PW-1:0]      hand_count,
	output logic                    busy,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output rrt_pkg::rsp_t           res_data
);

	localparam int A = rrt_pkg::ADDR_BITS;
	localparam int PD = TABLE_DEPTH + 2;

	// Piece buffer, filled by the walk and drained here in order.
	rrt_pkg::piece_t pb [PD];
	rrt_pkg::piece_t rd_s1;

	logic busy_q, zero_q, pend_s1, last_s1, drop_q, ov_q;
	logic [PW-1:0] n_q, k_q;
	rrt_pkg::rsp_t out_q;
	logic load_ok, take_pend, take_zero, issue;

	// Read a piece whenever the output register will have room for it.
	always_comb begin
		load_ok = !ov_q || res_ready;
		take_pend = pend_s1 && load_ok;
		take_zero = busy_q && zero_q && load_ok;
		issue = busy_q && !zero_q && (k_q < n_q) && (!pend_s1 || take_pend);
	end

	always_ff @(posedge clk) begin
		if (pc_wr.we) begin
			pb[pc_addr] <= pc_wr.piece;
		end
		if (issue) begin
			rd_s1 <= pb[k_q[PIW-1:0]];
			last_s1 <= (k_q + PW'(1)) == n_q;
		end
		if (hand.valid) begin
			n_q <= hand_count;
			drop_q <= hand.dropped;
		end
		// Output register load.
		if (take_pend) begin
			out_q.part_valid <= 1'b1;
			out_q.part_start <= rd_s1.start;
			out_q.part_length <= A'(rd_s1.end_addr - {1'b0, rd_s1.start});
			out_q.table_full <= drop_q;
			out_q.last <= last_s1;
		end else if (take_zero) begin
			out_q.part_valid <= 1'b0;
			out_q.part_start <= '0;
			out_q.part_length <= '0;
			out_q.table_full <= drop_q;
			out_q.last <= 1'b1;
		end
	end

	// Sequencing of one request's results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			zero_q <= 1'b0;
			pend_s1 <= 1'b0;
			ov_q <= 1'b0;
			k_q <= '0;
		end else begin
			if (hand.valid) begin
				busy_q <= 1'b1;
				zero_q <= (hand_count == '0);
				k_q <= '0;
			end else begin
				if (issue) begin
					k_q <= k_q + PW'(1);
				end
				if (take_zero || (take_pend && last_s1)) begin
					busy_q <= 1'b0;
					zero_q <= 1'b0;
				end
			end
			if (issue) begin
				pend_s1 <= 1'b1;
			end else if (take_pend) begin
				pend_s1 <= 1'b0;
			end
			if (take_pend || take_zero) begin
				ov_q <= 1'b1;
			end else if (res_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign res_valid = ov_q;
	assign res_data = out_q;

endmodule
`default_nettype wire

/* rtl/refcounted_range_table.sv */
// Reference-counted range table.
// A request on req_* adds (func 0) or removes (func 1) an address range.
// Results leave on res_*: an add gives the uncovered pieces, a remove gives
// the pieces whose count reached zero, in ascending order; last marks the
// final result of a request, and a request with nothing to report gives one
// result with part_valid low. table_full is set on every result of a request
// during which an entry was dropped for lack of room.
// One request is worked at a time. The walk reads the table memory once per
// stored entry, with an added write where a gap, the tail or a split needs
// one, then finishes and hands its pieces to the output stage; after the
// first result, one result follows per cycle while the receiver is ready.
// A zero-length request skips the walk and gives one empty result.
// req_ready rises again once the last result is loaded into the output
// register, so the next request is taken while that result still waits.
// A stalled receiver holds the output register and, through it, the piece
// buffer; the table itself is unaffected. Reset empties the table at once.
`default_nettype none
module refcounted_range_table #(
	parameter int TABLE_DEPTH = 16,
	parameter int REF_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire rrt_pkg::req_t req_data,
	output logic               res_valid,
	input  wire logic          res_ready,
	output rrt_pkg::rsp_t      res_data
);

	`include "refcounted_range_table_macros.svh"

	localparam int A = rrt_pkg::ADDR_BITS;
	localparam int PW = $clog2(TABLE_DEPTH + 3);
	localparam int PIW = $clog2(TABLE_DEPTH + 2);
	localparam rrt_pkg::addr_x_t ADDR_TOP = {1'b1, {A{1'b0}}};

	rrt_pkg::work_t work;
	rrt_pkg::addr_x_t sum;
	rrt_pkg::piece_wr_t pc_wr;
	logic [PIW-1:0] pc_addr;
	rrt_pkg::hand_t hand;
	logic [PW-1:0] hand_count;
	logic emit_busy, walk_idle, start;

	// Clip the range end at the top of the address space.
	always_comb begin
		sum = {1'b0, req_data.first_addr} + {1'b0, req_data.range_length};
		work.func = req_data.func;
		work.start = req_data.first_addr;
		work.end_addr = (sum > ADDR_TOP) ? ADDR_TOP : sum;
		work.noop = (req_data.range_length == '0);
	end

	assign req_ready = walk_idle;
	assign start = req_valid && req_ready;

	rrt_walk #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.REF_BITS(REF_BITS)
	) u_walk (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.work(work),
		.emit_busy(emit_busy),
		.idle(walk_idle),
		.pc_wr(pc_wr),
		.pc_addr(pc_addr),
		.hand(hand),
		.hand_count(hand_count)
	);

	rrt_emit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.pc_wr(pc_wr),
		.pc_addr(pc_addr),
		.hand(hand),
		.hand_count(hand_count),
		.busy(emit_busy),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	// Checks.
	`RRT_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request overlap")
	`RRT_ASSERT_NOW(a_empty_is_last, res_valid && !res_data.part_valid, res_data.last,
		"empty result not last")
	`RRT_ASSERT_NOW(a_piece_nonzero, res_valid && res_data.part_valid,
		res_data.part_length != '0, "zero-length piece")

endmodule
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int REF_BITS = 16;
	localparam logic [REF_BITS-1:0] REF_MAX = '1;
	localparam rrt_pkg::addr_x_t ADDR_TOP = rrt_pkg::addr_x_t'(1) << rrt_pkg::ADDR_BITS;
	localparam int IDLE_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 183;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	rrt_pkg::req_t req_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	rrt_pkg::rsp_t res_data;

	refcounted_range_table #(.TABLE_DEPTH(DEPTH), .REF_BITS(REF_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor copy of the range table.
	rrt_pkg::addr_x_t tbl_start[DEPTH];
	rrt_pkg::addr_x_t tbl_len[DEPTH];
	logic [REF_BITS-1:0] tbl_refs[DEPTH];
	int tbl_count;

	// Pieces emitted by the request being predicted.
	rrt_pkg::addr_x_t pc_start[$];
	rrt_pkg::addr_x_t pc_len[$];
	bit dropped_flag;

	rrt_pkg::rsp_t parts_due[$];
	rrt_pkg::rsp_t last_rsp;
	int error_count;
	int idle_cycles;

	task automatic store_piece(input rrt_pkg::addr_x_t s, input rrt_pkg::addr_x_t l);
		int pos;
		if (tbl_count >= DEPTH) begin
			dropped_flag = 1'b1;
			return;
		end
		pos = 0;
		while (pos < tbl_count && tbl_start[pos] < s)
			pos++;
		for (int k = tbl_count; k > pos; k--) begin
			tbl_start[k] = tbl_start[k-1];
			tbl_len[k] = tbl_len[k-1];
			tbl_refs[k] = tbl_refs[k-1];
		end
		tbl_start[pos] = s;
		tbl_len[pos] = l;
		tbl_refs[pos] = REF_BITS'(1);
		tbl_count++;
	endtask

	task automatic add_piece(input rrt_pkg::addr_x_t s, input rrt_pkg::addr_x_t l);
		pc_start = {pc_start, s};
		pc_len = {pc_len, l};
	endtask

	task automatic apply_add(input rrt_pkg::addr_x_t s, input rrt_pkg::addr_x_t e);
		rrt_pkg::addr_x_t cur;
		rrt_pkg::addr_x_t es;
		rrt_pkg::addr_x_t ee;
		cur = s;
		for (int i = 0; i < tbl_count; i++) begin
			es = tbl_start[i];
			ee = es + tbl_len[i];
			if (ee <= s || es >= e)
				continue;
			if (tbl_refs[i] != REF_MAX)
				tbl_refs[i]++;
			if (es > cur)
				add_piece(cur, es - cur);
			if (ee > cur)
				cur = ee;
		end
		if (cur < e)
			add_piece(cur, e - cur);
		for (int i = 0; i < pc_start.size(); i++)
			store_piece(pc_start[i], pc_len[i]);
	endtask

	task automatic apply_remove(input rrt_pkg::addr_x_t s, input rrt_pkg::addr_x_t e);
		rrt_pkg::addr_x_t ns[$];
		rrt_pkg::addr_x_t nl[$];
		logic [REF_BITS-1:0] nr[$];
		rrt_pkg::addr_x_t es;
		rrt_pkg::addr_x_t el;
		rrt_pkg::addr_x_t ee;
		logic [REF_BITS-1:0] r;
		bit zero;
		for (int i = 0; i < tbl_count; i++) begin
			es = tbl_start[i];
			el = tbl_len[i];
			ee = es + el;
			r = tbl_refs[i];
			if (e <= es || s >= ee) begin
				ns = {ns, es}; nl = {nl, el}; nr = {nr, r};
				continue;
			end
			if (r == 0)
				continue;
			r--;
			zero = (r == 0);
			if (es < s) begin
				ns = {ns, es}; nl = {nl, s - es}; nr = {nr, r};
				if (zero)
					add_piece(es, s - es);
			end
			if (ee > e) begin
				ns = {ns, e}; nl = {nl, ee - e}; nr = {nr, r};
				if (zero)
					add_piece(e, ee - e);
			end
			if (zero && es >= s && ee <= e)
				add_piece(es, el);
		end
		// The rebuilt table keeps only its lowest entries.
		if (ns.size() > DEPTH)
			dropped_flag = 1'b1;
		tbl_count = (ns.size() > DEPTH) ? DEPTH : ns.size();
		for (int i = 0; i < tbl_count; i++) begin
			tbl_start[i] = ns[i];
			tbl_len[i] = nl[i];
			tbl_refs[i] = nr[i];
		end
	endtask

	// Work out the parts one request produces and queue them.
	task automatic predict_parts(input rrt_pkg::req_t rq);
		rrt_pkg::addr_x_t s;
		rrt_pkg::addr_x_t e;
		rrt_pkg::rsp_t p;
		s = {1'b0, rq.first_addr};
		e = s + {1'b0, rq.range_length};
		if (e > ADDR_TOP)
			e = ADDR_TOP;
		pc_start.delete();
		pc_len.delete();
		dropped_flag = 1'b0;
		if (rq.range_length != 0) begin
			if (rq.func == rrt_pkg::FUNC_ADD)
				apply_add(s, e);
			else
				apply_remove(s, e);
		end
		if (pc_start.size() == 0) begin
			p = '0;
			p.table_full = dropped_flag;
			p.last = 1'b1;
			parts_due = {parts_due, p};
		end else begin
			for (int k = 0; k < pc_start.size(); k++) begin
				p.part_valid = 1'b1;
				p.part_start = pc_start[k][rrt_pkg::ADDR_BITS-1:0];
				p.part_length = pc_len[k][rrt_pkg::ADDR_BITS-1:0];
				p.table_full = dropped_flag;
				p.last = (k == pc_start.size() - 1);
				parts_due = {parts_due, p};
			end
		end
	endtask

	// Predict each accepted request and compare each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				predict_parts(req_data);
			if (res_valid && res_ready) begin
				last_rsp = res_data;
				if (parts_due.size() == 0) begin
					$display("%0t: unexpected result %p", $time, res_data);
					error_count++;
				end else if (res_data !== parts_due[0]) begin
					$display("%0t: expected %p, actual %p", $time, parts_due[0], res_data);
					error_count++;
					void'(parts_due.pop_front());
				end else begin
					void'(parts_due.pop_front());
				end
			end
			if ((req_valid && req_ready) || (res_valid && res_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// Receiver stalls in a pattern of its own, with stall-free stretches.
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if ((phase / 300) % 3 == 2)
				res_ready <= 1'b1;
			else
				res_ready <= ((phase % 7) < 4) || ($urandom_range(0, 3) == 0);
		end
	end

	// Directed requests; the first rows check plain expectations too.
	typedef struct {
		rrt_pkg::req_t rq;
		bit known;
		rrt_pkg::rsp_t part;
	} row_t;

	row_t rows[$];
	int gap_left;
	int burst_left;

	function automatic row_t mk(input logic f, input rrt_pkg::addr_t s,
		input rrt_pkg::addr_t l);
		row_t r;
		r.rq.func = f;
		r.rq.first_addr = s;
		r.rq.range_length = l;
		r.known = 1'b0;
		r.part = '0;
		return r;
	endfunction

	task automatic queue_row(input row_t r);
		rows = {rows, r};
	endtask

	// Each request is driven at a falling edge and dropped at the falling edge
	// after its acceptance.
	task automatic send_request(input rrt_pkg::req_t rq);
		if (burst_left == 0) begin
			gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 30);
			burst_left = $urandom_range(1, 12);
			repeat (gap_left) @(negedge clk);
		end
		burst_left--;
		@(negedge clk);
		req_data <= rq;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	function automatic rrt_pkg::addr_t rand_addr();
		return rrt_pkg::addr_t'({$urandom(), $urandom()});
	endfunction

	initial begin
		row_t r;
		rrt_pkg::req_t rq;
		rrt_pkg::addr_t base;
		rrt_pkg::addr_t spot[$];
		error_count = 0;
		idle_cycles = 0;
		tbl_count = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero length on an empty table gives one empty result.
		r = mk(rrt_pkg::FUNC_ADD, 48'h1000, 0);
		r.known = 1'b1; r.part.last = 1'b1; queue_row(r);
		// Remove on an empty table has nothing to emit.
		r = mk(rrt_pkg::FUNC_REMOVE, 48'h1000, 48'h100);
		r.known = 1'b1; r.part.last = 1'b1; queue_row(r);
		// First add returns the range itself.
		r = mk(rrt_pkg::FUNC_ADD, 48'h1000, 48'h100);
		r.known = 1'b1;
		r.part = '{1'b1, 48'h1000, 48'h100, 1'b0, 1'b1};
		queue_row(r);
		// Overlapping adds, split removes, whole-entry removes.
		queue_row(mk(rrt_pkg::FUNC_ADD, 48'h0f80, 48'h200));
		queue_row(mk(rrt_pkg::FUNC_ADD, 48'h1040, 48'h40));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h1050, 48'h10));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h1000, 48'h100));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h0f00, 48'h400));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h0f00, 48'h400));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h0, 48'hffff_ffff_ffff));
		// Range past the top is clipped; extremes of the fields.
		queue_row(mk(rrt_pkg::FUNC_ADD, 48'hffff_ffff_fff0, 48'hffff_ffff_ffff));
		queue_row(mk(rrt_pkg::FUNC_ADD, 48'h0, 48'hffff_ffff_ffff));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'hffff_ffff_ffff, 48'h1));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h0, 48'hffff_ffff_ffff));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h0, 48'hffff_ffff_ffff));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h0, 48'hffff_ffff_ffff));
		// Fill the table with small pieces and the gaps among them, then overflow it on a split.
		for (int i = 0; i < 8; i++)
			queue_row(mk(rrt_pkg::FUNC_ADD, rrt_pkg::addr_t'(i * 32), 48'h8));
		queue_row(mk(rrt_pkg::FUNC_ADD, 48'h0, 48'h400));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h2, 48'h2));
		queue_row(mk(rrt_pkg::FUNC_REMOVE, 48'h0, 48'hffff_ffff_ffff));

		foreach (rows[i]) begin
			send_request(rows[i].rq);
			if (rows[i].known) begin
				wait (parts_due.size() == 0);
				if (last_rsp !== rows[i].part) begin
					$display("%0t: expected %p, actual %p", $time, rows[i].part, last_rsp);
					error_count++;
				end
			end
		end

		// Random requests clustered near a few bases so ranges overlap.
		for (int i = 0; i < 8; i++)
			spot = {spot, {$urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom()), 32'h0}};
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			rq.func = $urandom_range(0, 99) < 55 ? rrt_pkg::FUNC_ADD : rrt_pkg::FUNC_REMOVE;
			case ($urandom_range(0, 9))
				0: begin
					rq.first_addr = rand_addr();
					rq.range_length = rand_addr();
				end
				1: begin
					rq.first_addr = rand_addr();
					rq.range_length = 0;
				end
				default: begin
					base = spot[$urandom_range(0, spot.size() - 1)];
					rq.first_addr = base + $urandom_range(0, 4095);
					rq.range_length = $urandom_range(1, 1024);
				end
			endcase
			send_request(rq);
		end

		wait (parts_due.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
`default_nettype wire
